// File: hw/rtl/slts_pkg.sv
// Shared types and constants for the token scanner: token kinds, character
// codes, the keyword table and the token and push request structs.
// No dependencies.
package slts_pkg;

    localparam int OFFSET_BITS_DEFAULT     = 16;
    localparam int KEYWORD_MAX_LEN_DEFAULT = 6;
    localparam int FIFO_DEPTH              = 4;
    localparam int KW_COUNT                = 16;
    localparam int KW_TEXT_LEN             = 6;

    typedef enum logic [5:0] {
        KIND_LEFT_PAREN, KIND_RIGHT_PAREN, KIND_LEFT_BRACE, KIND_RIGHT_BRACE,
        KIND_COMMA, KIND_DOT, KIND_MINUS, KIND_PLUS, KIND_SEMICOLON, KIND_SLASH,
        KIND_STAR, KIND_CARET, KIND_BANG, KIND_BANG_EQUAL, KIND_EQUAL,
        KIND_EQUAL_EQUAL, KIND_GREATER, KIND_GREATER_EQUAL, KIND_LESS,
        KIND_LESS_EQUAL, KIND_IDENTIFIER, KIND_STRING, KIND_NUMBER,
        KIND_AND, KIND_CLASS, KIND_ELSE, KIND_FALSE, KIND_FOR, KIND_FUN,
        KIND_IF, KIND_NIL, KIND_OR, KIND_PRINT, KIND_RETURN, KIND_SUPER,
        KIND_THIS, KIND_TRUE, KIND_VAR, KIND_WHILE, KIND_EOF, KIND_STRAY,
        KIND_UNTERMINATED
    } kind_t;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;

    // Keyword text, left-justified, zero padded; order follows the kind codes
    localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        {"and", 24'h0}, {"class", 8'h0}, {"else", 16'h0}, {"false", 8'h0},
        {"for", 24'h0}, {"fun", 24'h0},  {"if", 32'h0},   {"nil", 24'h0},
        {"or", 32'h0},  {"print", 8'h0}, {"return"},      {"super", 8'h0},
        {"this", 16'h0}, {"true", 16'h0}, {"var", 24'h0}, {"while", 8'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] line_number;
        logic [15:0] start_column;
        logic [15:0] end_column;
        logic [15:0] start_offset;
        logic        run_last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

endpackage

// File: hw/rtl/slts_in_if.sv
// Byte request channel of the token scanner: valid, ready and one source byte
// or the end marker. No dependencies.
interface slts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_marker;

    modport source (output valid, output char_byte, output end_marker, input ready);
    modport sink   (input valid, input char_byte, input end_marker, output ready);
endinterface

// File: hw/rtl/slts_tok_if.sv
// Token request channel of the token scanner: valid, ready and one token.
// No dependencies.
interface slts_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] start_column;
    logic [15:0] end_column;
    logic [15:0] start_offset;
    logic        run_last;

    modport source (output valid, output token_kind, output line_number,
                    output start_column, output end_column, output start_offset,
                    output run_last, input ready);
    modport sink   (input valid, input token_kind, input line_number,
                    input start_column, input end_column, input start_offset,
                    input run_last, output ready);
endinterface

// File: hw/rtl/slts_scan_core.sv
// Scanner state and the single-pass step logic: one byte or end marker in,
// up to two tokens out as a push request. Depends on slts_pkg.
module slts_scan_core #(
    parameter int OFFSET_BITS     = slts_pkg::OFFSET_BITS_DEFAULT,
    parameter int KEYWORD_MAX_LEN = slts_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      char_byte,
    input  logic            end_marker,
    output slts_pkg::push_t push
);
    import slts_pkg::*;

    localparam int OB  = OFFSET_BITS;
    localparam int KML = KEYWORD_MAX_LEN;
    localparam int WLW = $clog2(KML + 2);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_PEND, MODE_COMMENT, MODE_STRING,
        MODE_INT, MODE_FRAC, MODE_WORD
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [7:0]     pending_reg, pending_next;
    logic [7:0]     prefix_reg [KML];
    logic [7:0]     prefix_next [KML];
    logic [WLW-1:0] word_len_reg, word_len_next;
    logic [15:0]    line_reg, line_next;
    logic [OB-1:0]  offset_reg, offset_next;
    logic [OB-1:0]  base_reg, base_next;
    logic [OB-1:0]  start_reg, start_next;

    logic [OB-1:0]  off, prev;
    logic           is_digit, is_alpha, is_word_char;
    logic           ib_put, ib_pend, ib_word, ib_newline;
    logic [5:0]     ib_kind;
    mode_t          ib_mode;
    logic [5:0]     word_kind;
    logic           kw_hit;
    logic           run_idle, line_inc;
    logic           p0_v, p1_v;
    logic [5:0]     p0_kind, p1_kind;
    logic [OB-1:0]  p0_last, p1_start, p1_last;
    token_t         tok_a, tok_b;

    function automatic logic [5:0] pend_single(input logic [7:0] pc);
        case (pc)
            CH_BANG:    pend_single = KIND_BANG;
            CH_EQUAL:   pend_single = KIND_EQUAL;
            CH_GREATER: pend_single = KIND_GREATER;
            CH_LESS:    pend_single = KIND_LESS;
            default:    pend_single = KIND_SLASH;
        endcase
    endfunction

    function automatic logic [5:0] pend_double(input logic [7:0] pc);
        case (pc)
            CH_BANG:    pend_double = KIND_BANG_EQUAL;
            CH_EQUAL:   pend_double = KIND_EQUAL_EQUAL;
            CH_GREATER: pend_double = KIND_GREATER_EQUAL;
            CH_LESS:    pend_double = KIND_LESS_EQUAL;
            default:    pend_double = KIND_SLASH;
        endcase
    endfunction

    function automatic token_t make_token(
        input logic [5:0]    kind,
        input logic [OB-1:0] start,
        input logic [OB-1:0] last,
        input logic [OB-1:0] base,
        input logic [15:0]   line
    );
        token_t t;
        t.token_kind   = kind;
        t.line_number  = line;
        t.start_column = 16'(OB'(start - base));
        t.end_column   = 16'(OB'(last - base));
        t.start_offset = 16'(start);
        t.run_last     = 1'b1;
        return t;
    endfunction

    assign off  = offset_reg;
    assign prev = OB'(offset_reg - 1'b1);

    assign is_digit     = (char_byte >= CH_DIGIT_0) && (char_byte <= CH_DIGIT_9);
    assign is_alpha     = ((char_byte >= CH_LOWER_A) && (char_byte <= CH_LOWER_Z))
                       || ((char_byte >= CH_UPPER_A) && (char_byte <= CH_UPPER_Z));
    assign is_word_char = is_alpha || is_digit || (char_byte == CH_UNDERSCORE);

    // Decode of a byte seen with no token open
    always_comb
    begin
        ib_put     = 1'b0;
        ib_kind    = KIND_STRAY;
        ib_mode    = MODE_IDLE;
        ib_pend    = 1'b0;
        ib_word    = 1'b0;
        ib_newline = 1'b0;
        case (char_byte)
            CH_LPAREN:    begin ib_put = 1'b1; ib_kind = KIND_LEFT_PAREN;  end
            CH_RPAREN:    begin ib_put = 1'b1; ib_kind = KIND_RIGHT_PAREN; end
            CH_LBRACE:    begin ib_put = 1'b1; ib_kind = KIND_LEFT_BRACE;  end
            CH_RBRACE:    begin ib_put = 1'b1; ib_kind = KIND_RIGHT_BRACE; end
            CH_COMMA:     begin ib_put = 1'b1; ib_kind = KIND_COMMA;       end
            CH_DOT:       begin ib_put = 1'b1; ib_kind = KIND_DOT;         end
            CH_MINUS:     begin ib_put = 1'b1; ib_kind = KIND_MINUS;       end
            CH_PLUS:      begin ib_put = 1'b1; ib_kind = KIND_PLUS;        end
            CH_SEMICOLON: begin ib_put = 1'b1; ib_kind = KIND_SEMICOLON;   end
            CH_STAR:      begin ib_put = 1'b1; ib_kind = KIND_STAR;        end
            CH_CARET:     begin ib_put = 1'b1; ib_kind = KIND_CARET;       end
            CH_BANG, CH_EQUAL, CH_GREATER, CH_LESS, CH_SLASH:
            begin
                ib_pend = 1'b1;
                ib_mode = MODE_PEND;
            end
            CH_QUOTE:     ib_mode = MODE_STRING;
            CH_SPACE, CH_TAB, CH_CR: ib_mode = MODE_IDLE;
            CH_NEWLINE:   ib_newline = 1'b1;
            default:
            begin
                if (is_digit)
                begin
                    ib_mode = MODE_INT;
                end
                else if (is_alpha || (char_byte == CH_UNDERSCORE))
                begin
                    ib_word = 1'b1;
                    ib_mode = MODE_WORD;
                end
                else
                begin
                    ib_put = 1'b1;
                end
            end
        endcase
    end

    // Keyword lookup over the stored prefix
    always_comb
    begin
        word_kind = KIND_IDENTIFIER;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            kw_hit = (word_len_reg == WLW'(KW_LEN[i]));
            for (int j = 0; j < KW_TEXT_LEN; j++)
            begin
                kw_hit = kw_hit && (prefix_reg[j] == KW_TEXT[i][8*(KW_TEXT_LEN-1-j) +: 8]);
            end
            if (kw_hit)
            begin
                word_kind = 6'(KIND_AND) + 6'(i);
            end
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        pending_next  = pending_reg;
        prefix_next   = prefix_reg;
        word_len_next = word_len_reg;
        offset_next   = offset_reg;
        base_next     = base_reg;
        start_next    = start_reg;
        run_idle      = 1'b0;
        line_inc      = 1'b0;
        p0_v          = 1'b0;
        p0_kind       = KIND_NUMBER;
        p0_last       = prev;
        p1_v          = 1'b0;
        p1_kind       = KIND_EOF;
        p1_start      = start_reg;
        p1_last       = prev;

        if (fire)
        begin
            if (end_marker)
            begin
                case (mode_reg)
                    MODE_PEND:
                    begin
                        p0_v    = 1'b1;
                        p0_kind = pend_single(pending_reg);
                    end
                    MODE_INT, MODE_FRAC: p0_v = 1'b1;
                    MODE_WORD:
                    begin
                        p0_v    = 1'b1;
                        p0_kind = word_kind;
                    end
                    MODE_STRING:
                    begin
                        p0_v    = 1'b1;
                        p0_kind = KIND_UNTERMINATED;
                    end
                    default: p0_v = 1'b0;
                endcase
                mode_next = MODE_IDLE;
                p1_v      = 1'b1;
            end
            else
            begin
                offset_next = OB'(off + 1'b1);
                case (mode_reg)
                    MODE_PEND:
                    begin
                        if ((char_byte == CH_EQUAL) && (pending_reg != CH_SLASH))
                        begin
                            p0_v      = 1'b1;
                            p0_kind   = pend_double(pending_reg);
                            p0_last   = off;
                            mode_next = MODE_IDLE;
                        end
                        else if ((char_byte == CH_SLASH) && (pending_reg == CH_SLASH))
                        begin
                            mode_next = MODE_COMMENT;
                        end
                        else
                        begin
                            p0_v     = 1'b1;
                            p0_kind  = pend_single(pending_reg);
                            run_idle = 1'b1;
                        end
                    end
                    MODE_COMMENT: run_idle = (char_byte == CH_NEWLINE);
                    MODE_STRING:
                    begin
                        if (char_byte == CH_QUOTE)
                        begin
                            p0_v      = 1'b1;
                            p0_kind   = KIND_STRING;
                            p0_last   = off;
                            mode_next = MODE_IDLE;
                        end
                        else if (char_byte == CH_NEWLINE)
                        begin
                            line_inc = 1'b1;
                        end
                    end
                    MODE_INT:
                    begin
                        if (char_byte == CH_DOT)
                        begin
                            mode_next = MODE_FRAC;
                        end
                        else if (!is_digit)
                        begin
                            p0_v     = 1'b1;
                            run_idle = 1'b1;
                        end
                    end
                    MODE_FRAC:
                    begin
                        if (!is_digit)
                        begin
                            p0_v     = 1'b1;
                            run_idle = 1'b1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_word_char)
                        begin
                            for (int j = 0; j < KML; j++)
                            begin
                                if (word_len_reg == WLW'(j))
                                begin
                                    prefix_next[j] = char_byte;
                                end
                            end
                            if (word_len_reg <= WLW'(KML))
                            begin
                                word_len_next = WLW'(word_len_reg + 1'b1);
                            end
                        end
                        else
                        begin
                            p0_v     = 1'b1;
                            p0_kind  = word_kind;
                            run_idle = 1'b1;
                        end
                    end
                    default: run_idle = 1'b1;
                endcase

                if (run_idle)
                begin
                    start_next = off;
                    mode_next  = ib_mode;
                    p1_v       = ib_put;
                    p1_kind    = ib_kind;
                    p1_start   = off;
                    p1_last    = off;
                    if (ib_pend)
                    begin
                        pending_next = char_byte;
                    end
                    if (ib_word)
                    begin
                        for (int j = 0; j < KML; j++)
                        begin
                            prefix_next[j] = 8'h00;
                        end
                        prefix_next[0] = char_byte;
                        word_len_next  = WLW'(1);
                    end
                    if (ib_newline)
                    begin
                        line_inc  = 1'b1;
                        base_next = OB'(off + 1'b1);
                    end
                end
            end
        end

        line_next = (line_inc && (line_reg != 16'hFFFF)) ? 16'(line_reg + 1'b1) : line_reg;
    end

    always_comb
    begin
        tok_a = make_token(p1_kind, p1_start, p1_last, base_reg, line_reg);
        if (p0_v)
        begin
            tok_a = make_token(p0_kind, start_reg, p0_last, base_reg, line_reg);
        end
        tok_a.run_last = !(p0_v && p1_v);
        tok_b          = make_token(p1_kind, p1_start, p1_last, base_reg, line_reg);
        push.count     = 2'(p0_v) + 2'(p1_v);
        push.first     = tok_a;
        push.second    = tok_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            pending_reg  <= 8'h00;
            for (int j = 0; j < KML; j++)
            begin
                prefix_reg[j] <= 8'h00;
            end
            word_len_reg <= '0;
            line_reg     <= 16'd1;
            offset_reg   <= '0;
            base_reg     <= '0;
            start_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            pending_reg  <= pending_next;
            prefix_reg   <= prefix_next;
            word_len_reg <= word_len_next;
            line_reg     <= line_next;
            offset_reg   <= offset_next;
            base_reg     <= base_next;
            start_reg    <= start_next;
        end
    end

`ifndef SYNTHESIS
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 16'd0)
        else $error("line count reached zero");

    a_word_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_len_reg <= WLW'(KML + 1))
        else $error("word length beyond saturation point");

    a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_WORD) |-> (word_len_reg != '0))
        else $error("word scan open with empty prefix");
`endif

endmodule

// File: hw/rtl/slts_token_fifo.sv
// Token queue between the scan step and the token channel: takes up to two
// tokens a cycle, gives one while the channel is ready. Depends on slts_pkg and slts_tok_if.
module slts_token_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  slts_pkg::push_t push,
    output logic            room,
    slts_tok_if.source      tok_ch
);
    import slts_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = PW + 1;

    token_t        mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    token_t        head;

    assign room = (count_reg <= CW'(FIFO_DEPTH - 2));
    assign pop  = tok_ch.valid && tok_ch.ready;
    assign head = mem[rd_ptr_reg];

    assign tok_ch.valid        = (count_reg != '0);
    assign tok_ch.token_kind   = head.token_kind;
    assign tok_ch.line_number  = head.line_number;
    assign tok_ch.start_column = head.start_column;
    assign tok_ch.end_column   = head.end_column;
    assign tok_ch.start_offset = head.start_offset;
    assign tok_ch.run_last     = head.run_last;

    always_comb
    begin
        wr_ptr_next = PW'(wr_ptr_reg + push.count);
        rd_ptr_next = PW'(rd_ptr_reg + pop);
        count_next  = CW'(count_reg + CW'(push.count) - CW'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[PW'(wr_ptr_reg + 1'b1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("token queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("push into a queue without room for a pair");

    a_pair_together: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_ch.valid && !tok_ch.run_last) |-> (count_reg >= CW'(2)))
        else $error("first token of a pair queued without its partner");
`endif

endmodule

// File: hw/rtl/script_lexer_token_scanner.sv
// Token scanner top level: byte input register, scan step, token queue.
// A byte waits in the input register until the queue has room for a pair; its tokens are then queued.
// Throughput: one byte per cycle while the queue has room for a pair; a byte giving two tokens holds the
// token port for both, and the four-entry token queue and the one-token-per-cycle output port set the sustained rate.
// Reset: asynchronous; line 1, offset 0, no open token, queue empty; no clearing pass.
// Depends on slts_pkg, slts_in_if, slts_tok_if, slts_scan_core, slts_token_fifo.
module script_lexer_token_scanner #(
    parameter int OFFSET_BITS     = slts_pkg::OFFSET_BITS_DEFAULT,
    parameter int KEYWORD_MAX_LEN = slts_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    slts_in_if.sink     in_ch,
    slts_tok_if.source  tok_ch
);
    import slts_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       end_reg;
    logic       accept;
    logic       fire;
    logic       room;
    push_t      push;

    assign fire        = in_valid_reg && room;
    assign in_ch.ready = !in_valid_reg || fire;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= in_ch.char_byte;
            end_reg  <= in_ch.end_marker;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    slts_scan_core #(
        .OFFSET_BITS     (OFFSET_BITS),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .char_byte  (char_reg),
        .end_marker (end_reg),
        .push       (push)
    );

    slts_token_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .tok_ch (tok_ch)
    );

endmodule

// File: tb/sv/script_lexer_token_scanner_checker.sv
`timescale 1ns / 1ps
// Token checker for the script lexer token scanner: watches both request channels,
// predicts the tokens of every accepted byte or end marker and compares them in order.
// Depends on slts_pkg.
module script_lexer_token_scanner_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        end_marker,
    input  logic        tok_valid,
    input  logic        tok_ready,
    input  logic [5:0]  token_kind,
    input  logic [15:0] line_number,
    input  logic [15:0] start_column,
    input  logic [15:0] end_column,
    input  logic [15:0] start_offset,
    input  logic        run_last,
    output int          fail_count,
    output int          outstanding
);
    import slts_pkg::*;

    localparam int WORD_KEEP = KEYWORD_MAX_LEN_DEFAULT;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_OPERATOR, SCAN_COMMENT, SCAN_QUOTED,
        SCAN_INTEGER, SCAN_FRACTION, SCAN_WORD
    } scan_state_t;

    string keywords [KW_COUNT] = '{
        "and", "class", "else", "false", "for", "fun", "if", "nil",
        "or", "print", "return", "super", "this", "true", "var", "while"
    };

    scan_state_t scan_state;
    logic [7:0]  held_op;
    logic [7:0]  word_head [WORD_KEEP];
    int          word_len;
    logic [15:0] line_cnt;
    logic [15:0] offset;
    logic [15:0] base;
    logic [15:0] scan_start;
    token_t      expected_tokens [$];
    token_t      step_tokens [$];

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic kind_t operator_kind(logic [7:0] op);
        case (op)
            CH_BANG:    return KIND_BANG;
            CH_EQUAL:   return KIND_EQUAL;
            CH_GREATER: return KIND_GREATER;
            CH_LESS:    return KIND_LESS;
            default:    return KIND_SLASH;
        endcase
    endfunction

    function automatic kind_t word_kind();
        bit hit;
        if (word_len > WORD_KEEP)
            return KIND_IDENTIFIER;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (keywords[i].len() == word_len)
            begin
                hit = 1'b1;
                for (int j = 0; j < word_len; j++)
                begin
                    if (keywords[i][j] != word_head[j])
                        hit = 1'b0;
                end
                if (hit)
                    return kind_t'(int'(KIND_AND) + i);
            end
        end
        return KIND_IDENTIFIER;
    endfunction

    function automatic void bump_line();
        if (line_cnt != 16'hFFFF)
            line_cnt = line_cnt + 16'd1;
    endfunction

    function automatic void emit(kind_t kind, logic [15:0] first, logic [15:0] last);
        token_t t;
        t.token_kind   = kind;
        t.line_number  = line_cnt;
        t.start_column = first - base;
        t.end_column   = last - base;
        t.start_offset = first;
        t.run_last     = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void scan_fresh(logic [7:0] c, logic [15:0] off);
        scan_start = off;
        scan_state = SCAN_IDLE;
        case (c)
            CH_LPAREN:    emit(KIND_LEFT_PAREN, off, off);
            CH_RPAREN:    emit(KIND_RIGHT_PAREN, off, off);
            CH_LBRACE:    emit(KIND_LEFT_BRACE, off, off);
            CH_RBRACE:    emit(KIND_RIGHT_BRACE, off, off);
            CH_COMMA:     emit(KIND_COMMA, off, off);
            CH_DOT:       emit(KIND_DOT, off, off);
            CH_MINUS:     emit(KIND_MINUS, off, off);
            CH_PLUS:      emit(KIND_PLUS, off, off);
            CH_SEMICOLON: emit(KIND_SEMICOLON, off, off);
            CH_STAR:      emit(KIND_STAR, off, off);
            CH_CARET:     emit(KIND_CARET, off, off);
            CH_BANG, CH_EQUAL, CH_GREATER, CH_LESS, CH_SLASH:
            begin
                held_op    = c;
                scan_state = SCAN_OPERATOR;
            end
            CH_QUOTE:     scan_state = SCAN_QUOTED;
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_NEWLINE:
            begin
                bump_line();
                base = off + 16'd1;
            end
            default:
            begin
                if (is_digit(c))
                    scan_state = SCAN_INTEGER;
                else if (is_letter(c) || c == CH_UNDERSCORE)
                begin
                    foreach (word_head[i])
                        word_head[i] = '0;
                    word_head[0] = c;
                    word_len     = 1;
                    scan_state   = SCAN_WORD;
                end
                else
                    emit(KIND_STRAY, off, off);
            end
        endcase
    endfunction

    function automatic void predict_request(logic em, logic [7:0] c);
        logic [15:0] off;
        logic [15:0] prev;
        off  = offset;
        prev = offset - 16'd1;
        step_tokens.delete();
        if (em)
        begin
            case (scan_state)
                SCAN_OPERATOR:               emit(operator_kind(held_op), scan_start, prev);
                SCAN_INTEGER, SCAN_FRACTION: emit(KIND_NUMBER, scan_start, prev);
                SCAN_WORD:                   emit(word_kind(), scan_start, prev);
                SCAN_QUOTED:                 emit(KIND_UNTERMINATED, scan_start, prev);
                default: ;
            endcase
            scan_state = SCAN_IDLE;
            emit(KIND_EOF, scan_start, prev);
        end
        else
        begin
            case (scan_state)
                SCAN_OPERATOR:
                begin
                    if (c == CH_EQUAL && held_op != CH_SLASH)
                    begin
                        emit(kind_t'(int'(operator_kind(held_op)) + 1), scan_start, off);
                        scan_state = SCAN_IDLE;
                    end
                    else if (c == CH_SLASH && held_op == CH_SLASH)
                        scan_state = SCAN_COMMENT;
                    else
                    begin
                        emit(operator_kind(held_op), scan_start, prev);
                        scan_fresh(c, off);
                    end
                end
                SCAN_COMMENT:
                begin
                    if (c == CH_NEWLINE)
                        scan_fresh(c, off);
                end
                SCAN_QUOTED:
                begin
                    if (c == CH_QUOTE)
                    begin
                        emit(KIND_STRING, scan_start, off);
                        scan_state = SCAN_IDLE;
                    end
                    else if (c == CH_NEWLINE)
                        bump_line();
                end
                SCAN_INTEGER:
                begin
                    if (c == CH_DOT)
                        scan_state = SCAN_FRACTION;
                    else if (!is_digit(c))
                    begin
                        emit(KIND_NUMBER, scan_start, prev);
                        scan_fresh(c, off);
                    end
                end
                SCAN_FRACTION:
                begin
                    if (!is_digit(c))
                    begin
                        emit(KIND_NUMBER, scan_start, prev);
                        scan_fresh(c, off);
                    end
                end
                SCAN_WORD:
                begin
                    if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE)
                    begin
                        if (word_len < WORD_KEEP)
                            word_head[word_len] = c;
                        if (word_len <= WORD_KEEP)
                            word_len++;
                    end
                    else
                    begin
                        emit(word_kind(), scan_start, prev);
                        scan_fresh(c, off);
                    end
                end
                default: scan_fresh(c, off);
            endcase
            offset = off + 16'd1;
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].run_last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_token();
        token_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("token_kind: expected none, got %0d at offset %0d", token_kind, start_offset);
            fail_count++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            compare_field("token_kind", 16'(want.token_kind), 16'(token_kind));
            compare_field("line_number", want.line_number, line_number);
            compare_field("start_column", want.start_column, start_column);
            compare_field("end_column", want.end_column, end_column);
            compare_field("start_offset", want.start_offset, start_offset);
            compare_field("run_last", 16'(want.run_last), 16'(run_last));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state = SCAN_IDLE;
            held_op    = '0;
            foreach (word_head[i])
                word_head[i] = '0;
            word_len   = 0;
            line_cnt   = 16'd1;
            offset     = '0;
            base       = '0;
            scan_start = '0;
            expected_tokens.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(end_marker, char_byte);
            if (tok_valid && tok_ready)
                check_token();
            outstanding <= expected_tokens.size();
        end
    end

endmodule

// File: tb/sv/script_lexer_token_scanner_tb.sv
`timescale 1ns / 1ps
// Top of the token scanner testbench: clock, reset, byte and end-marker requests,
// token back-pressure, stall watchdog and verdict.
// Depends on slts_pkg, slts_in_if, slts_tok_if and script_lexer_token_scanner_checker.
module script_lexer_token_scanner_tb;
    import slts_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int REQUEST_COUNT = 500;
    localparam int CALM_TAIL     = 80;

    logic clk;
    logic rst_n;
    bit   source_idling;
    bit   sink_idling;
    int   sent;
    int   fail_count;
    int   outstanding;
    int   quiet_cycles = 0;

    string keywords [KW_COUNT] = '{
        "and", "class", "else", "false", "for", "fun", "if", "nil",
        "or", "print", "return", "super", "this", "true", "var", "while"
    };
    string operators = "(){},.-+;*^!=<>/";

    slts_in_if  in_if();
    slts_tok_if tok_if();

    script_lexer_token_scanner uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_if),
        .tok_ch(tok_if)
    );

    script_lexer_token_scanner_checker token_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_if.valid),
        .in_ready    (in_if.ready),
        .char_byte   (in_if.char_byte),
        .end_marker  (in_if.end_marker),
        .tok_valid   (tok_if.valid),
        .tok_ready   (tok_if.ready),
        .token_kind  (tok_if.token_kind),
        .line_number (tok_if.line_number),
        .start_column(tok_if.start_column),
        .end_column  (tok_if.end_column),
        .start_offset(tok_if.start_offset),
        .run_last    (tok_if.run_last),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (tok_if.valid && tok_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : sink_side
        int hold;
        tok_if.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (sink_idling && $urandom_range(0, 2) == 0)
                begin
                    tok_if.ready <= 1'b0;
                    hold = $urandom_range(1, 18);
                end
                else
                begin
                    tok_if.ready <= 1'b1;
                    hold = $urandom_range(1, 30);
                end
            end
            hold--;
        end
    end

    task automatic send_request(logic em, logic [7:0] b);
        if (source_idling && $urandom_range(0, 3) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.char_byte  <= b;
        in_if.end_marker <= em;
        do
            @(posedge clk);
        while (!in_if.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request(1'b0, b);
    endtask

    task automatic send_end();
        send_request(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // hold the source until every predicted token has been taken
    task automatic drain_tokens();
        in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        @(negedge clk);
    endtask

    function automatic logic [7:0] word_char(bit leading);
        int r;
        r = $urandom_range(0, leading ? 52 : 62);
        if (r < 26)
            return CH_LOWER_A + 8'(r);
        if (r < 52)
            return CH_UPPER_A + 8'(r - 26);
        if (r == 52)
            return CH_UNDERSCORE;
        return CH_DIGIT_0 + 8'(r - 53);
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_DIGIT_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_NEWLINE;
        endcase
    endfunction

    task automatic send_fragment();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            send_text(keywords[$urandom_range(0, KW_COUNT - 1)]);
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_byte(word_char(1'b0));
        end
        else if (pick < 30)
        begin
            send_byte(word_char(1'b1));
            repeat ($urandom_range(0, 9)) send_byte(word_char(1'b0));
        end
        else if (pick < 42)
        begin
            repeat ($urandom_range(1, 4)) send_byte(digit_char());
            if ($urandom_range(0, 1) == 0)
            begin
                send_byte(CH_DOT);
                repeat ($urandom_range(0, 3)) send_byte(digit_char());
            end
        end
        else if (pick < 52)
        begin
            send_byte(CH_QUOTE);
            repeat ($urandom_range(0, 8))
            begin
                c = ($urandom_range(0, 7) == 0) ? CH_NEWLINE : 8'($urandom_range(8'h20, 8'h7E));
                send_byte(c == CH_QUOTE ? CH_SPACE : c);
            end
            if ($urandom_range(0, 9) != 0)
                send_byte(CH_QUOTE);
        end
        else if (pick < 67)
        begin
            send_byte(operators[$urandom_range(0, operators.len() - 1)]);
            if ($urandom_range(0, 1) == 0)
                send_byte(CH_EQUAL);
        end
        else if (pick < 74)
        begin
            send_text("//");
            repeat ($urandom_range(0, 6))
            begin
                c = 8'($urandom_range(0, 255));
                send_byte(c == CH_NEWLINE ? CH_SPACE : c);
            end
            if ($urandom_range(0, 4) != 0)
                send_byte(CH_NEWLINE);
        end
        else if (pick < 86)
            repeat ($urandom_range(1, 3)) send_byte(blank_char());
        else if (pick < 95)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_end();
    endtask

    initial
    begin : stimulus
        bit paused;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.char_byte  = '0;
        in_if.end_marker = 1'b0;
        source_idling    = 1'b1;
        sink_idling      = 1'b1;
        sent             = 0;
        paused           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty source, then a number with a bare fraction ended by a word and a bracket
        send_end();
        send_text("1._(");
        send_text("!=");
        send_text("//c");
        send_end();
        send_byte(CH_QUOTE);
        send_byte(CH_NEWLINE);
        send_end();
        send_byte(CH_EQUAL);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("while");
        send_end();
        drain_tokens();

        while (sent < REQUEST_COUNT)
        begin
            if (sent >= REQUEST_COUNT - CALM_TAIL)
            begin
                source_idling = 1'b0;
                sink_idling   = 1'b0;
            end
            else
            begin
                source_idling = ($urandom_range(0, 4) != 0);
                sink_idling   = ($urandom_range(0, 4) != 0);
            end
            if (!paused && sent >= REQUEST_COUNT / 2)
            begin
                paused = 1'b1;
                drain_tokens();
            end
            send_fragment();
        end
        send_end();

        in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
